@@ hdl/joint_direction_velocity_feature_defines.svh @@
// Assertion macros for the joint direction / velocity feature block.
// Included by the top level; no other dependencies.
`ifndef JOINT_DIRECTION_VELOCITY_FEATURE_DEFINES_SVH
`define JOINT_DIRECTION_VELOCITY_FEATURE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JDV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jdv assertion failed");

// Next-cycle implication, disabled during reset.
`define JDV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jdv assertion failed");

`endif

@@ hdl/jdv_pkg.sv @@
// Shared types and constants for the joint direction / velocity feature block.
// No dependencies.
package jdv_pkg;

  localparam int AD_W      = 16;  // magnitude of a coordinate difference
  localparam int SQ_W      = 32;  // square of a difference magnitude
  localparam int S_W       = 34;  // sum of three squares, also divider denominator
  localparam int T_W       = 16;  // frame interval
  localparam int W_W       = 8;   // velocity weight
  localparam int AW_W      = AD_W + W_W;
  localparam int VEL_SHIFT = 13;  // 2 * 2^12 for round-half-up numerator
  localparam int VN_W      = AW_W + VEL_SHIFT + 1;
  localparam int OUT_W     = 20;

  localparam longint unsigned OUT_POS_MAX = 64'd524287;
  localparam longint unsigned OUT_NEG_MAX = 64'd524288;

  localparam logic           CFG_IDX_WEIGHT = 1'b0;
  localparam logic [W_W-1:0] WEIGHT_RESET   = 8'd48;

  // Per-item sideband that travels alongside the arithmetic
  typedef struct packed {
    logic       func;
    logic       zero;
    logic [2:0] neg;
  } jdv_side_t;

  // Operands handed from the front end to the divider
  typedef struct packed {
    jdv_side_t               side;
    logic [2:0][S_W-1:0]     rem0;
    logic [S_W-1:0]          den;
    logic [2:0][VN_W-1:0]    num;
  } jdv_front_t;

endpackage

@@ hdl/jdv_front.sv @@
// Front end: differences, squares, weight products and divider operands.
// Three register stages; depends on jdv_pkg.
module jdv_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               func_i,
  input  logic [2:0][jdv_pkg::AD_W-1:0]      first_i,
  input  logic [2:0][jdv_pkg::AD_W-1:0]      second_i,
  input  logic [jdv_pkg::T_W-1:0]            interval_i,
  input  logic [jdv_pkg::W_W-1:0]            weight_i,
  output logic                               valid_o,
  output jdv_pkg::jdv_front_t                data_o
);
  import jdv_pkg::*;

  logic                  v1_q, v2_q, v3_q;
  logic                  func1_q, func2_q;
  logic [2:0]            neg1_q, neg2_q;
  logic [2:0][AD_W-1:0]  ad1_q, ad1_d;
  logic [2:0]            neg1_d;
  logic [T_W-1:0]        t1_q, t2_q;
  logic [2:0][SQ_W-1:0]  sq2_q;
  logic [2:0][AW_W-1:0]  aw2_q;
  jdv_front_t            data3_q, data3_d;

  // Stage 1: signed difference and its magnitude
  always_comb begin
    logic signed [AD_W:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({first_i[k][AD_W-1], first_i[k]})
           - $signed({second_i[k][AD_W-1], second_i[k]});
      neg1_d[k] = diff[AD_W];
      ad1_d[k]  = diff[AD_W] ? AD_W'(-diff) : diff[AD_W-1:0];
    end
  end

  // Stage 3: sum of squares and operands for the shared divider
  always_comb begin
    logic [S_W-1:0] s;
    s = S_W'(sq2_q[0]) + S_W'(sq2_q[1]) + S_W'(sq2_q[2]);
    data3_d.side.func = func2_q;
    data3_d.side.neg  = neg2_q;
    data3_d.side.zero = func2_q ? (t2_q == '0) : (s == '0);
    data3_d.den       = func2_q ? S_W'({t2_q, 1'b0}) : s;
    for (int k = 0; k < 3; k++) begin
      data3_d.rem0[k] = func2_q ? '0 : S_W'(sq2_q[k]);
      data3_d.num[k]  = func2_q ? ((VN_W'(aw2_q[k]) << VEL_SHIFT) + VN_W'(t2_q)) : '0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func1_q <= func_i;
      neg1_q  <= neg1_d;
      ad1_q   <= ad1_d;
      t1_q    <= interval_i;
      func2_q <= func1_q;
      neg2_q  <= neg1_q;
      t2_q    <= t1_q;
      for (int k = 0; k < 3; k++) begin
        sq2_q[k] <= SQ_W'(ad1_q[k]) * SQ_W'(ad1_q[k]);
        aw2_q[k] <= AW_W'(ad1_q[k]) * AW_W'(weight_i);
      end
      data3_q <= data3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = data3_q;

endmodule

@@ hdl/jdv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Depends on jdv_pkg.
module jdv_div #(
  parameter int F_BITS = 12,
  parameter int STEPS  = 38
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  jdv_pkg::jdv_front_t           data_i,
  output logic                          valid_o,
  output jdv_pkg::jdv_side_t            side_o,
  output logic [2:0][STEPS-1:0]         quo_o
);
  import jdv_pkg::*;

  // Direction division runs only in the last 2F+2 stages
  localparam int DIR_START = STEPS - (2 * F_BITS + 2);

  logic [STEPS:0]                 v;
  jdv_side_t                      side [STEPS+1];
  logic [S_W-1:0]                 den  [STEPS+1];
  logic [2:0][S_W-1:0]            rem  [STEPS+1];
  logic [2:0][STEPS-1:0]          quo  [STEPS+1];
  logic [2:0][STEPS-1:0]          num  [STEPS+1];

  assign v[0]    = valid_i;
  assign side[0] = data_i.side;
  assign den[0]  = data_i.den;
  assign rem[0]  = data_i.rem0;
  assign quo[0]  = '0;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[0][k] = STEPS'(data_i.num[k]);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic DIR_ON = (i >= DIR_START);
    logic [2:0][S_W-1:0]   rem_d;
    logic [2:0][STEPS-1:0] quo_d;
    logic [2:0][STEPS-1:0] num_d;

    // Shift in one numerator bit, compare, subtract
    always_comb begin
      logic [S_W:0] trial;
      for (int k = 0; k < 3; k++) begin
        trial = {rem[i][k], num[i][k][STEPS-1]};
        if (side[i].func || DIR_ON) begin
          num_d[k] = num[i][k] << 1;
          if (trial >= {1'b0, den[i]}) begin
            rem_d[k] = S_W'(trial - {1'b0, den[i]});
            quo_d[k] = {quo[i][k][STEPS-2:0], 1'b1};
          end else begin
            rem_d[k] = trial[S_W-1:0];
            quo_d[k] = {quo[i][k][STEPS-2:0], 1'b0};
          end
        end else begin
          num_d[k] = num[i][k];
          rem_d[k] = rem[i][k];
          quo_d[k] = quo[i][k];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[i+1] <= 1'b0;
      end else if (en_i) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side[i+1] <= side[i];
        den[i+1]  <= den[i];
        rem[i+1]  <= rem_d;
        quo[i+1]  <= quo_d;
        num[i+1]  <= num_d;
      end
    end
  end

  assign valid_o = v[STEPS];
  assign side_o  = side[STEPS];
  assign quo_o   = quo[STEPS];

endmodule

@@ hdl/jdv_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Carries the quotient through for velocity items; depends on jdv_pkg.
module jdv_sqrt #(
  parameter int F_BITS = 12,
  parameter int QW     = 38
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  jdv_pkg::jdv_side_t            side_i,
  input  logic [2:0][QW-1:0]            quo_i,
  output logic                          valid_o,
  output jdv_pkg::jdv_side_t            side_o,
  output logic [2:0][QW-1:0]            quo_o,
  output logic [2:0][F_BITS+1:0]        root_o
);
  import jdv_pkg::*;

  localparam int RB = F_BITS + 2;
  localparam int XW = (2 * RB > QW) ? 2 * RB : QW;

  logic [RB:0]                 v;
  jdv_side_t                   side [RB+1];
  logic [2:0][QW-1:0]          quo  [RB+1];
  logic [2:0][2*RB-1:0]        rad  [RB+1];
  logic [2:0][RB+1:0]          rem  [RB+1];
  logic [2:0][RB-1:0]          root [RB+1];

  assign v[0]    = valid_i;
  assign side[0] = side_i;
  assign quo[0]  = quo_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  always_comb begin
    logic [XW-1:0] qx;
    for (int k = 0; k < 3; k++) begin
      qx        = XW'(quo_i[k]);
      rad[0][k] = qx[2*RB-1:0];
    end
  end

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [2:0][2*RB-1:0] rad_d;
    logic [2:0][RB+1:0]   rem_d;
    logic [2:0][RB-1:0]   root_d;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      logic [RB+3:0] trial;
      logic [RB+3:0] cand;
      for (int k = 0; k < 3; k++) begin
        trial    = {rem[i][k], rad[i][k][2*RB-1 -: 2]};
        cand     = (RB+4)'({root[i][k], 2'b01});
        rad_d[k] = rad[i][k] << 2;
        if (trial >= cand) begin
          rem_d[k]  = (RB+2)'(trial - cand);
          root_d[k] = {root[i][k][RB-2:0], 1'b1};
        end else begin
          rem_d[k]  = trial[RB+1:0];
          root_d[k] = {root[i][k][RB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[i+1] <= 1'b0;
      end else if (en_i) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side[i+1] <= side[i];
        quo[i+1]  <= quo[i];
        rad[i+1]  <= rad_d;
        rem[i+1]  <= rem_d;
        root[i+1] <= root_d;
      end
    end
  end

  assign valid_o = v[RB];
  assign side_o  = side[RB];
  assign quo_o   = quo[RB];
  assign root_o  = root[RB];

endmodule

@@ hdl/jdv_back.sv @@
// Output stage: rounding of the direction root, zero cases, saturation, sign.
// Holds the output register; depends on jdv_pkg.
module jdv_back #(
  parameter int F_BITS = 12,
  parameter int QW     = 38
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  jdv_pkg::jdv_side_t                side_i,
  input  logic [2:0][QW-1:0]                quo_i,
  input  logic [2:0][F_BITS+1:0]            root_i,
  output logic                              valid_o,
  output logic [2:0][jdv_pkg::OUT_W-1:0]    out_o,
  output logic                              saturated_o
);
  import jdv_pkg::*;

  localparam int RB = F_BITS + 2;
  localparam int MW = (QW > RB + 1) ? QW : RB + 1;

  logic                   valid_q;
  logic [2:0][OUT_W-1:0]  out_q, out_d;
  logic                   sat_q, sat_d;

  // Pick the magnitude, clip it and apply the sign
  always_comb begin
    logic [MW-1:0]    mag;
    logic [OUT_W-1:0] m20;
    logic             neg;
    sat_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (side_i.zero) begin
        mag = '0;
      end else if (side_i.func) begin
        mag = MW'(quo_i[k]);
      end else begin
        mag = MW'((MW'(root_i[k]) + MW'(1)) >> 1);
      end
      neg = side_i.neg[k] && (mag != '0);
      if (!neg && (mag > MW'(OUT_POS_MAX))) begin
        sat_d = 1'b1;
        m20   = OUT_W'(OUT_POS_MAX);
      end else if (neg && (mag > MW'(OUT_NEG_MAX))) begin
        sat_d = 1'b1;
        m20   = OUT_W'(OUT_NEG_MAX);
      end else begin
        m20 = mag[OUT_W-1:0];
      end
      out_d[k] = neg ? (~m20 + OUT_W'(1)) : m20;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o     = valid_q;
  assign out_o       = out_q;
  assign saturated_o = sat_q;

endmodule

@@ hdl/joint_direction_velocity_feature.sv @@
// Top level of the joint direction / velocity feature block.
// Depends on jdv_pkg, jdv_front, jdv_div, jdv_sqrt, jdv_back and the defines header.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one transaction per item: mode bit,
//   two 3D joint positions and a frame interval. Output channel out_valid_o /
//   out_stall_i returns one transaction per item with the vector and a clip flag.
//   Mode 0 gives the rounded unit direction of first - second; mode 1 gives the
//   difference divided by the interval and scaled by velocity_weight.
//   A transaction moves when valid is high and stall is low.
//   Throughput: one item per cycle while the output is not stalled. Items pass through
//   the front end, the bit-per-stage divider (STEPS = max(2*COORD_FRAC_BITS + 2, 38))
//   and square-root pipelines and the output register.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall_o rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits and sets velocity_weight to 3.0 (48).
//   velocity_weight sits at APB address 0; write it only while the block is idle.
module joint_direction_velocity_feature #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [15:0]            first_x_i,
  input  logic signed [15:0]            first_y_i,
  input  logic signed [15:0]            first_z_i,
  input  logic signed [15:0]            second_x_i,
  input  logic signed [15:0]            second_y_i,
  input  logic signed [15:0]            second_z_i,
  input  logic [15:0]                   interval_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [19:0]            out_x_o,
  output logic signed [19:0]            out_y_o,
  output logic signed [19:0]            out_z_o,
  output logic                          saturated_o
);
  import jdv_pkg::*;
  `include "joint_direction_velocity_feature_defines.svh"

  localparam int STEPS = (2 * COORD_FRAC_BITS + 2 > VN_W) ? 2 * COORD_FRAC_BITS + 2 : VN_W;

  logic                      en;
  logic [W_W-1:0]            weight_q;
  logic                      cfg_wr;
  logic [2:0][AD_W-1:0]      first, second;
  logic                      f_valid, d_valid, s_valid;
  jdv_front_t                f_data;
  jdv_side_t                 d_side, s_side;
  logic [2:0][STEPS-1:0]     d_quo, s_quo;
  logic [2:0][COORD_FRAC_BITS+1:0] s_root;
  logic [2:0][OUT_W-1:0]     out;
  logic                      at_limit;

  // Hold every stage while a finished result is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_WEIGHT);
  assign prdata = (paddr[2] == CFG_IDX_WEIGHT) ? 32'(weight_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      weight_q <= pwdata[W_W-1:0];
    end
  end

  assign first  = {first_z_i, first_y_i, first_x_i};
  assign second = {second_z_i, second_y_i, second_x_i};

  jdv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .func_i     (func_i),
    .first_i    (first),
    .second_i   (second),
    .interval_i (interval_i),
    .weight_i   (weight_q),
    .valid_o    (f_valid),
    .data_o     (f_data)
  );

  jdv_div #(
    .F_BITS (COORD_FRAC_BITS),
    .STEPS  (STEPS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (d_valid),
    .side_o  (d_side),
    .quo_o   (d_quo)
  );

  jdv_sqrt #(
    .F_BITS (COORD_FRAC_BITS),
    .QW     (STEPS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .quo_i   (d_quo),
    .valid_o (s_valid),
    .side_o  (s_side),
    .quo_o   (s_quo),
    .root_o  (s_root)
  );

  jdv_back #(
    .F_BITS (COORD_FRAC_BITS),
    .QW     (STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_valid),
    .side_i      (s_side),
    .quo_i       (s_quo),
    .root_i      (s_root),
    .valid_o     (out_valid_o),
    .out_o       (out),
    .saturated_o (saturated_o)
  );

  assign out_x_o = out[0];
  assign out_y_o = out[1];
  assign out_z_o = out[2];

  // Flag a result with any component at a range limit
  assign at_limit = (out_x_o == 20'sd524287) || (out_x_o == -20'sd524288)
                 || (out_y_o == 20'sd524287) || (out_y_o == -20'sd524288)
                 || (out_z_o == 20'sd524287) || (out_z_o == -20'sd524288);

  // Input stalls only behind a stalled result
  `JDV_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // A clipped result has a component at a range limit
  `JDV_ASSERT_IMP(a_sat_limit, clk_i, rst_ni, out_valid_o && saturated_o, at_limit)
  // Weight write lands in the register
  `JDV_ASSERT_NXT(a_cfg_write, clk_i, rst_ni, cfg_wr, weight_q == $past(pwdata[W_W-1:0]))

endmodule
